// File: src/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg: shared types for the combine-and-sort block
// Controller states and the command and status groups that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cas_pkg;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;     // Insert the incoming beat into the cell chain.
        logic shift_out;  // Drop the head cell and move the chain down.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_one;   // Exactly one stored value remains.
        logic dropped;    // A value of this set was discarded.
    } sts_t;

endpackage

// File: src/combine_and_sort_values.sv
// Latency: the first result beat is valid in the cycle after the marked input beat.
// Throughput: one input beat per cycle while loading, one result beat per cycle
// while emitting and m_tready is high; a set of n input beats gives min(n, CAPACITY)
// result beats.
// No input beat is taken while a run is being emitted; the cell chain does both.
// Reset (aresetn low, synchronous) empties the store and clears the overflow flag.
// ----------------------------------------------------------------------------
// combine_and_sort_values: streaming sorter for a combined set of values
// Stores signed values in sorted order as they arrive and, after the marked
// final beat, emits them in ascending order with a flag for dropped values.
// ----------------------------------------------------------------------------
module combine_and_sort_values #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,   // [DATA_WIDTH-1:0] value
    input  logic                                  s_tlast,   // last_in
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,   // [DATA_WIDTH-1:0] sorted_value
    output logic                                  m_tlast,   // last_out
    output logic                                  m_tuser    // [0] dropped
);
    import cas_pkg::*;

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    cmd_t                  cmd;
    sts_t                  sts;
    logic [DATA_WIDTH-1:0] head_value;

    // Sequencing.
    cas_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    // Sorted storage.
    cas_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_value   (s_tdata[DATA_WIDTH-1:0]),
        .sts        (sts),
        .head_value (head_value)
    );

    assign m_tdata = TDATA_W'(head_value);
    assign m_tlast = sts.last_one;
    assign m_tuser = sts.dropped;

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output channels active together");

    // After the final result beat the block loads again.
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to loading after the run");

    // A run continues until its final beat.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("run ended without a final beat");

    // The dropped flag is the same on every beat of a run.
    a_flag_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> $stable(m_tuser))
        else $error("dropped flag changed within a run");

endmodule

// File: src/cas_datapath.sv
// ----------------------------------------------------------------------------
// cas_datapath: insertion cell chain
// Keeps the stored values in ascending signed order. Each inserted value
// is written straight into its sorted place; emission reads the head cell and
// shifts the chain down by one.
// ----------------------------------------------------------------------------
module cas_datapath #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cas_pkg::cmd_t         cmd,
    input  logic [DATA_WIDTH-1:0] in_value,
    output cas_pkg::sts_t         sts,
    output logic [DATA_WIDTH-1:0] head_value
);
    import cas_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] cell_reg [CAPACITY];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  full;
    logic [CAPACITY-1:0]   gt;
    logic [DATA_WIDTH-1:0] in_key;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign in_key = {~in_value[DATA_WIDTH-1], in_value[DATA_WIDTH-2:0]};

    // A cell is "greater" when it holds a larger value or lies past the fill.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cmp
            logic [DATA_WIDTH-1:0] cell_key;
            assign cell_key = {~cell_reg[gi][DATA_WIDTH-1], cell_reg[gi][DATA_WIDTH-2:0]};
            assign gt[gi]   = (CNT_W'(gi) >= count_reg) || (cell_key > in_key);
        end
    endgenerate

    // Cell updates: insert in place, or shift toward the head on emission.
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            always_ff @(posedge aclk) begin
                if (cmd.insert && !full) begin
                    if (gt[gi]) begin
                        if (gi == 0) begin
                            cell_reg[gi] <= in_value;
                        end else if (!gt[(gi > 0) ? gi - 1 : 0]) begin
                            cell_reg[gi] <= in_value;
                        end else begin
                            cell_reg[gi] <= cell_reg[(gi > 0) ? gi - 1 : 0];
                        end
                    end
                end else if (cmd.shift_out) begin
                    if (gi < CAPACITY - 1) begin
                        cell_reg[gi] <= cell_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    end
                end
            end
        end
    endgenerate

    // Fill count and overflow flag.
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.insert) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (cmd.shift_out) begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign sts.last_one = (count_reg == CNT_W'(1));
    assign sts.dropped  = ovf_reg;
    assign head_value   = cell_reg[0];

endmodule

// File: src/cas_controller.sv
// ----------------------------------------------------------------------------
// cas_controller: load and emit sequencing
// Accepts beats until the marked one, then hands out the stored values one
// beat at a time until the chain is empty.
// ----------------------------------------------------------------------------
module cas_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    input  logic          m_tready,
    input  cas_pkg::sts_t sts,
    output cas_pkg::cmd_t cmd,
    output logic          s_tready,
    output logic          m_tvalid
);
    import cas_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        cmd.insert    = 1'b0;
        cmd.shift_out = 1'b0;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.insert = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.shift_out = 1'b1;
                    if (sts.last_one) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for combine_and_sort_values
// Streams sets of signed values into the sorter. A short table of directed
// sets comes first, then random sets of mixed sizes, some overflowing the store.
// Result beats are checked against a sorted-store predictor or typed-in results.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY     = 32;
    localparam int DATA_WIDTH   = 32;
    localparam int TDATA_WIDTH  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 425;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;

    localparam elem_t MOST_NEG = elem_t'(32'h8000_0000);
    localparam elem_t MOST_POS = elem_t'(32'h7FFF_FFFF);

    // One result beat: value, end-of-run mark and overflow flag.
    typedef struct packed {
        elem_t value;
        logic  last;
        logic  dropped;
    } sorted_beat_t;

    // One directed input beat; want holds a typed-in result for one-value sets.
    typedef struct packed {
        elem_t        value;
        logic         last_in;
        logic         typed;
        sorted_beat_t want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 19;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // One-value sets at the extremes of the range, at zero and at minus one.
        '{MOST_NEG, 1'b1, 1'b1, '{MOST_NEG, 1'b1, 1'b0}},
        '{MOST_POS, 1'b1, 1'b1, '{MOST_POS, 1'b1, 1'b0}},
        '{elem_t'(0), 1'b1, 1'b1, '{elem_t'(0), 1'b1, 1'b0}},
        '{elem_t'(-1), 1'b1, 1'b1, '{elem_t'(-1), 1'b1, 1'b0}},
        // Mixed signs, both extremes and a duplicate in one set.
        '{elem_t'(7), 1'b0, 1'b0, '0},
        '{elem_t'(-7), 1'b0, 1'b0, '0},
        '{MOST_POS, 1'b0, 1'b0, '0},
        '{MOST_NEG, 1'b0, 1'b0, '0},
        '{elem_t'(7), 1'b0, 1'b0, '0},
        '{elem_t'(0), 1'b1, 1'b0, '0},
        // Alternating bit patterns with a repeated value.
        '{elem_t'(32'h5555_5555), 1'b0, 1'b0, '0},
        '{elem_t'(32'hAAAA_AAAA), 1'b0, 1'b0, '0},
        '{elem_t'(32'h5555_5555), 1'b1, 1'b0, '0},
        // Values arriving in descending order.
        '{elem_t'(100), 1'b0, 1'b0, '0},
        '{elem_t'(99), 1'b0, 1'b0, '0},
        '{elem_t'(98), 1'b0, 1'b0, '0},
        '{elem_t'(-98), 1'b1, 1'b0, '0},
        // Two equal values.
        '{elem_t'(-5), 1'b0, 1'b0, '0},
        '{elem_t'(-5), 1'b1, 1'b0, '0}
    };

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_WIDTH-1:0] s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_WIDTH-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // Predictor state: values of the current set kept in ascending order.
    elem_t        held_vals [CAPACITY];
    int           held_count    = 0;
    bit           set_overflow  = 1'b0;
    sorted_beat_t sorted_run_q [$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 28;
    int recv_idle_pct   = 83;

    combine_and_sort_values #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tlast  (s_tlast),   // last_in
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] sorted_value
        .m_tlast  (m_tlast),   // last_out
        .m_tuser  (m_tuser)    // [0] dropped
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Files one accepted value into the predicted store. On the marked beat the
    // stored run goes to the expected queue (unless typed in) and the store empties.
    task automatic store_and_sort(input elem_t v, input logic last_in, input bit keep_run);
        int pos;
        if (held_count < CAPACITY) begin
            pos = held_count;
            while (pos > 0 && held_vals[pos-1] > v) begin
                held_vals[pos] = held_vals[pos-1];
                pos--;
            end
            held_vals[pos] = v;
            held_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (last_in) begin
            if (keep_run) begin
                for (int i = 0; i < held_count; i++) begin
                    sorted_run_q.push_back('{held_vals[i], (i == held_count - 1), set_overflow});
                end
            end
            held_count   = 0;
            set_overflow = 1'b0;
        end
    endtask

    // Drives one input beat, with random idle cycles ahead of it, and waits
    // for it to be taken.
    task automatic send_element(input elem_t v, input logic last_in, input bit typed,
                                input sorted_beat_t want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last_in;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        store_and_sort(v, last_in, !typed);
        if (typed && last_in) begin
            sorted_run_q.push_back(want);
        end
    endtask

    // Mix of full-range values, small values that repeat, and near-extremes.
    function automatic elem_t pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 5) begin
            return elem_t'($urandom);
        end else if (sel <= 7) begin
            return elem_t'($urandom_range(16)) - elem_t'(8);
        end else if (sel == 8) begin
            return MOST_NEG + elem_t'($urandom_range(3));
        end else begin
            return MOST_POS - elem_t'($urandom_range(3));
        end
    endfunction

    // Result side: check each accepted beat and stall at random.
    always @(posedge aclk) begin
        sorted_beat_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (sorted_run_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result beat value=%0d last=%b dropped=%b",
                                        $signed(m_tdata[DATA_WIDTH-1:0]), m_tlast, m_tuser));
            end else begin
                want = sorted_run_q.pop_front();
                if (m_tdata[DATA_WIDTH-1:0] !== want.value || m_tlast !== want.last ||
                    m_tuser !== want.dropped) begin
                    note_mismatch($sformatf(
                        "expected value=%0d last=%b dropped=%b, got value=%0d last=%b dropped=%b",
                        want.value, want.last, want.dropped,
                        $signed(m_tdata[DATA_WIDTH-1:0]), m_tlast, m_tuser));
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stimulus: reset, directed table, random sets, then drain.
    initial begin
        int set_size;
        int big_sets;
        int sent;
        big_sets = 0;
        sent     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_element(DIRECTED[r].value, DIRECTED[r].last_in, DIRECTED[r].typed,
                         DIRECTED[r].want);
        end

        // Random sets; about one in five has CAPACITY-1 to CAPACITY+4 values.
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end else if (sent >= RANDOM_ITEMS / 3) begin
                sender_idle_pct = 83;
                recv_idle_pct   = 28;
            end
            if ($urandom_range(4) == 0) begin
                set_size = CAPACITY - 1 + (big_sets % 6);
                big_sets++;
            end else begin
                set_size = $urandom_range(12, 1);
            end
            for (int k = 0; k < set_size; k++) begin
                send_element(pick_value(), (k == set_size - 1), 1'b0, '0);
            end
            sent += set_size;
        end
        s_tvalid <= 1'b0;

        while (sorted_run_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && sorted_run_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
